>>> hw/rtl/phe_pkg.sv
`default_nettype none
package phe_pkg;

   localparam logic [127:0] FIVE_POW_16  = 128'd152587890625;
   localparam int           SCALE_FRAC   = 16;
   localparam int           ERR_SQ_SHIFT = 32;

   localparam logic [1:0] CSR_SCALE   = 2'd0;
   localparam logic [1:0] CSR_HOMO_EN = 2'd1;
   localparam logic [1:0] CSR_HOMO_W  = 2'd2;

   // program counter marks in the apex sequence
   localparam logic [3:0] PC_LAST_GEOM = 4'd11;
   localparam logic [3:0] PC_LAST      = 4'd15;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SH_GO, ST_SH_WAIT, ST_SLOT, ST_MP_GO, ST_MP_WAIT,
      ST_SQ_GO, ST_SQ_WAIT, ST_DV_GO, ST_DV_WAIT, ST_HGT, ST_FIN
   } state_type;

   typedef enum logic [4:0] {
      MOP_SHX, MOP_SHY, MOP_SHZ,
      MOP_C0A, MOP_C0B, MOP_C1A, MOP_C1B, MOP_C2A, MOP_C2B,
      MOP_N0, MOP_N1, MOP_N2, MOP_D0, MOP_D1, MOP_D2,
      MOP_EH, MOP_ET, MOP_E2, MOP_EK
   } mop_type;

   typedef enum logic [3:0] {
      ACT_NONE, ACT_P, ACT_HELD, ACT_C0, ACT_C1, ACT_C2, ACT_NORM, ACT_DOT,
      ACT_ERR, ACT_E2, ACT_ENERGY, ACT_HGT, ACT_FIN
   } act_type;

   typedef struct packed {
      mop_type mop;
      logic    clr;
      act_type act;
   } prog_type;

   typedef struct packed {
      logic       capture;
      logic       mul_start;
      mop_type    mop;
      logic       clr;
      act_type    act;
      logic [1:0] idx;
      logic       sqrt_start;
      logic       div_start;
   } cmd_type;

   typedef struct packed {
      logic mul_busy;
      logic sqrt_busy;
      logic div_busy;
      logic degen;
      logic counted;
      logic out_free;
   } stat_type;

   function automatic prog_type prog_step(input logic [3:0] pc);
      prog_type p;
      p = '{mop: MOP_C0A, clr: 1'b1, act: ACT_NONE};
      case (pc)
         4'd0:  p = '{mop: MOP_C0A, clr: 1'b1, act: ACT_NONE};
         4'd1:  p = '{mop: MOP_C0B, clr: 1'b0, act: ACT_C0};
         4'd2:  p = '{mop: MOP_C1A, clr: 1'b1, act: ACT_NONE};
         4'd3:  p = '{mop: MOP_C1B, clr: 1'b0, act: ACT_C1};
         4'd4:  p = '{mop: MOP_C2A, clr: 1'b1, act: ACT_NONE};
         4'd5:  p = '{mop: MOP_C2B, clr: 1'b0, act: ACT_C2};
         4'd6:  p = '{mop: MOP_N0,  clr: 1'b1, act: ACT_NONE};
         4'd7:  p = '{mop: MOP_N1,  clr: 1'b0, act: ACT_NONE};
         4'd8:  p = '{mop: MOP_N2,  clr: 1'b0, act: ACT_NORM};
         4'd9:  p = '{mop: MOP_D0,  clr: 1'b1, act: ACT_NONE};
         4'd10: p = '{mop: MOP_D1,  clr: 1'b0, act: ACT_NONE};
         4'd11: p = '{mop: MOP_D2,  clr: 1'b0, act: ACT_DOT};
         4'd12: p = '{mop: MOP_EH,  clr: 1'b1, act: ACT_NONE};
         4'd13: p = '{mop: MOP_ET,  clr: 1'b0, act: ACT_ERR};
         4'd14: p = '{mop: MOP_E2,  clr: 1'b1, act: ACT_E2};
         4'd15: p = '{mop: MOP_EK,  clr: 1'b1, act: ACT_ENERGY};
         default: p = '{mop: MOP_C0A, clr: 1'b1, act: ACT_NONE};
      endcase
      return p;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/phe_mul.sv
`default_nettype none
// 96x64 sign-magnitude multiply-accumulate, one 32x32 partial product per cycle
module phe_mul (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                clr,
   input  wire logic                sub,
   input  wire logic signed [96:0]  a,
   input  wire logic signed [64:0]  b,
   output logic                     busy,
   output logic [127:0]             acc
);
   logic [95:0]  am_ff;
   logic [63:0]  bm_ff;
   logic         neg_ff;
   logic [1:0]   ai_ff;
   logic         bi_ff;
   logic         issue_ff;
   logic         ppv_ff;
   logic [63:0]  pp_ff;
   logic [1:0]   sh_ff;
   logic [127:0] acc_ff;

   logic [96:0]  a_neg;
   logic [64:0]  b_neg;
   logic [95:0]  a_abs;
   logic [63:0]  b_abs;
   logic [127:0] term;
   logic [127:0] acc_in;

   always_comb begin
      a_neg  = -a;
      b_neg  = -b;
      a_abs  = a[96] ? a_neg[95:0] : a[95:0];
      b_abs  = b[64] ? b_neg[63:0] : b[63:0];
      term   = {64'd0, pp_ff} << {sh_ff, 5'd0};
      acc_in = neg_ff ? acc_ff - term : acc_ff + term;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         ppv_ff   <= 1'b0;
         ai_ff    <= 2'd0;
         bi_ff    <= 1'b0;
      end else begin
         ppv_ff <= issue_ff & ~start;
         if (start) begin
            issue_ff <= 1'b1;
            ai_ff    <= 2'd0;
            bi_ff    <= 1'b0;
         end else if (issue_ff) begin
            if (bi_ff) begin
               bi_ff <= 1'b0;
               if (ai_ff == 2'd2) begin
                  issue_ff <= 1'b0;
               end else begin
                  ai_ff <= ai_ff + 2'd1;
               end
            end else begin
               bi_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         am_ff  <= a_abs;
         bm_ff  <= b_abs;
         neg_ff <= a[96] ^ b[64] ^ sub;
      end
      pp_ff <= am_ff[{ai_ff, 5'd0} +: 32] * bm_ff[{bi_ff, 5'd0} +: 32];
      sh_ff <= ai_ff + {1'b0, bi_ff};
      if (start && clr) begin
         acc_ff <= '0;
      end else if (ppv_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign busy = issue_ff | ppv_ff;
   assign acc  = acc_ff;
endmodule
`default_nettype wire

>>> hw/rtl/phe_dp.sv
`default_nettype none
module phe_dp #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire phe_pkg::cmd_type  cmd,
   output phe_pkg::stat_type      stat,
   input  wire logic [31:0]       req_pos_x,
   input  wire logic [31:0]       req_pos_y,
   input  wire logic [31:0]       req_pos_z,
   input  wire logic [31:0]       req_disp_x,
   input  wire logic [31:0]       req_disp_y,
   input  wire logic [31:0]       req_disp_z,
   input  wire logic              req_atom_active,
   input  wire logic [31:0]       req_force_const,
   input  wire logic [31:0]       req_target_height,
   input  wire logic              req_list_end,
   input  wire logic              csr_valid,
   input  wire logic [1:0]        csr_index,
   input  wire logic [31:0]       csr_data,
   input  wire logic              rsp_stall,
   output logic                   rsp_valid,
   output logic [63:0]            rsp_term_energy,
   output logic [31:0]            rsp_height,
   output logic [31:0]            rsp_height_error,
   output logic                   rsp_term_counted,
   output logic [63:0]            rsp_running_energy,
   output logic                   rsp_list_done
);
   localparam logic [127:0] THR =
      ((128'd1 << (4 * FRAC_BITS - 16)) / phe_pkg::FIVE_POW_16) + 128'd1;

   function automatic logic [63:0] s64(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      logic [31:0] r;
      if (v > 64'sd2147483647) r = 32'h7fffffff;
      else if (v < -64'sd2147483648) r = 32'h80000000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic [96:0] ax(input logic [63:0] v);
      return {{33{v[63]}}, v};
   endfunction

   function automatic logic [64:0] bx(input logic [63:0] v);
      return {v[63], v};
   endfunction

   // configuration
   logic [17:0] scale_ff;
   logic        homo_en_ff;
   logic [16:0] homo_w_ff;

   // captured item
   logic [31:0] pos_ff  [3];
   logic [31:0] disp_ff [3];
   logic [31:0] k_ff;
   logic [31:0] t_ff;
   logic        end_ff;
   logic        any_ff;

   // shifted positions: current, origin, right, left
   logic [31:0] p_ff   [3];
   logic [31:0] org_ff [3];
   logic [31:0] rgt_ff [3];
   logic [31:0] lft_ff [3];

   logic [63:0]  c_ff [3];
   logic [127:0] norm2_ff;
   logic [127:0] dot_ff;
   logic [31:0]  h_ff;
   logic [31:0]  herr_ff;
   logic [63:0]  err_ff;
   logic [95:0]  e2_ff;
   logic [63:0]  energy_ff;
   logic [63:0]  sum_ff;
   logic         rsp_valid_ff;

   // square root
   logic [127:0] src_ff;
   logic [66:0]  srem_ff;
   logic [63:0]  root_ff;
   logic [5:0]   scnt_ff;
   logic         sbusy_ff;
   // divide
   logic [95:0]  dvd_ff;
   logic [63:0]  drem_ff;
   logic [6:0]   dcnt_ff;
   logic         dbusy_ff;
   logic         dneg_ff;

   logic [31:0]  dr [3];
   logic [31:0]  dl [3];
   logic [31:0]  da [3];
   logic [96:0]  mul_a;
   logic [64:0]  mul_b;
   logic         mul_sub;
   logic         mul_busy;
   logic [127:0] acc;
   logic [15:0]  w_eff;
   logic         skip_w;
   logic         degen;
   logic         counted;
   logic [63:0]  shq;
   logic [31:0]  p_new;
   logic [66:0]  srem_t;
   logic [66:0]  strial;
   logic [64:0]  drem_t;
   logic [127:0] dot_neg;
   logic [95:0]  dmag;
   logic [31:0]  h_q;
   logic [127:0] prod_sh;
   logic [63:0]  energy_c;
   logic [63:0]  e_add;
   logic [64:0]  sum_wide;
   logic [63:0]  sum_new;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dr[i] = sat32(s64(rgt_ff[i]) - s64(org_ff[i]));
         dl[i] = sat32(s64(lft_ff[i]) - s64(org_ff[i]));
         da[i] = sat32(s64(p_ff[i]) - s64(org_ff[i]));
      end
      skip_w = homo_en_ff & homo_w_ff[16];
      w_eff  = homo_en_ff ? homo_w_ff[15:0] : 16'd0;
   end

   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_sub = 1'b0;
      case (cmd.mop)
         phe_pkg::MOP_SHX: begin mul_a = {{79{scale_ff[17]}}, scale_ff};
                                 mul_b = bx(s64(disp_ff[0])); end
         phe_pkg::MOP_SHY: begin mul_a = {{79{scale_ff[17]}}, scale_ff};
                                 mul_b = bx(s64(disp_ff[1])); end
         phe_pkg::MOP_SHZ: begin mul_a = {{79{scale_ff[17]}}, scale_ff};
                                 mul_b = bx(s64(disp_ff[2])); end
         phe_pkg::MOP_C0A: begin mul_a = ax(s64(dr[1])); mul_b = bx(s64(dl[2])); end
         phe_pkg::MOP_C0B: begin mul_a = ax(s64(dl[1])); mul_b = bx(s64(dr[2]));
                                 mul_sub = 1'b1; end
         phe_pkg::MOP_C1A: begin mul_a = ax(s64(dl[0])); mul_b = bx(s64(dr[2])); end
         phe_pkg::MOP_C1B: begin mul_a = ax(s64(dr[0])); mul_b = bx(s64(dl[2]));
                                 mul_sub = 1'b1; end
         phe_pkg::MOP_C2A: begin mul_a = ax(s64(dr[0])); mul_b = bx(s64(dl[1])); end
         phe_pkg::MOP_C2B: begin mul_a = ax(s64(dl[0])); mul_b = bx(s64(dr[1]));
                                 mul_sub = 1'b1; end
         phe_pkg::MOP_N0:  begin mul_a = ax(c_ff[0]); mul_b = bx(c_ff[0]); end
         phe_pkg::MOP_N1:  begin mul_a = ax(c_ff[1]); mul_b = bx(c_ff[1]); end
         phe_pkg::MOP_N2:  begin mul_a = ax(c_ff[2]); mul_b = bx(c_ff[2]); end
         phe_pkg::MOP_D0:  begin mul_a = ax(c_ff[0]); mul_b = bx(s64(da[0])); end
         phe_pkg::MOP_D1:  begin mul_a = ax(c_ff[1]); mul_b = bx(s64(da[1])); end
         phe_pkg::MOP_D2:  begin mul_a = ax(c_ff[2]); mul_b = bx(s64(da[2])); end
         phe_pkg::MOP_EH:  begin mul_a = ax(s64(h_ff));
                                 mul_b = {47'd0, 18'h10000 + {2'b00, w_eff}}; end
         phe_pkg::MOP_ET:  begin mul_a = ax(s64(t_ff));
                                 mul_b = {47'd0, 18'h10000 - {2'b00, w_eff}};
                                 mul_sub = 1'b1; end
         phe_pkg::MOP_E2:  begin mul_a = ax(err_ff); mul_b = bx(err_ff); end
         phe_pkg::MOP_EK:  begin mul_a = {1'b0, e2_ff}; mul_b = {33'd0, k_ff}; end
         default: ;
      endcase
   end

   phe_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .clr   (cmd.clr),
      .sub   (mul_sub),
      .a     (mul_a),
      .b     (mul_b),
      .busy  (mul_busy),
      .acc   (acc)
   );

   always_comb begin
      shq     = $signed(acc[63:0]) >>> phe_pkg::SCALE_FRAC;
      p_new   = sat32(s64(pos_ff[cmd.idx]) + shq);
      srem_t  = {srem_ff[64:0], src_ff[127:126]};
      strial  = {1'b0, root_ff, 2'b01};
      drem_t  = {drem_ff, dvd_ff[95]};
      dot_neg = -dot_ff;
      dmag    = dot_ff[127] ? dot_neg[95:0] : dot_ff[95:0];
      if (dneg_ff) begin
         h_q = (dvd_ff > 96'h80000000) ? 32'h80000000 : (32'd0 - dvd_ff[31:0]);
      end else begin
         h_q = (dvd_ff > 96'h7fffffff) ? 32'h7fffffff : dvd_ff[31:0];
      end
      degen    = (norm2_ff < THR) || (root_ff == 64'd0);
      counted  = any_ff & ~degen & ~skip_w;
      prod_sh  = acc >> FRAC_BITS;
      energy_c = (|prod_sh[127:64]) ? 64'hffffffffffffffff : prod_sh[63:0];
      e_add    = counted ? energy_ff : 64'd0;
      sum_wide = {1'b0, sum_ff} + {1'b0, e_add};
      sum_new  = sum_wide[64] ? 64'hffffffffffffffff : sum_wide[63:0];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= '0;
         homo_en_ff   <= 1'b0;
         homo_w_ff    <= '0;
         any_ff       <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         sbusy_ff     <= 1'b0;
         dbusy_ff     <= 1'b0;
         scnt_ff      <= '0;
         dcnt_ff      <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               phe_pkg::CSR_SCALE:   scale_ff   <= csr_data[17:0];
               phe_pkg::CSR_HOMO_EN: homo_en_ff <= csr_data[0];
               phe_pkg::CSR_HOMO_W:  homo_w_ff  <= csr_data[16:0];
               default: ;
            endcase
         end
         if (cmd.capture) begin
            any_ff <= any_ff | req_atom_active;
         end
         if (cmd.act == phe_pkg::ACT_FIN) begin
            any_ff       <= 1'b0;
            sum_ff       <= end_ff ? 64'd0 : sum_new;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.sqrt_start) begin
            sbusy_ff <= 1'b1;
            scnt_ff  <= '0;
         end else if (sbusy_ff) begin
            scnt_ff <= scnt_ff + 6'd1;
            if (scnt_ff == 6'd63) sbusy_ff <= 1'b0;
         end
         if (cmd.div_start) begin
            dbusy_ff <= 1'b1;
            dcnt_ff  <= '0;
         end else if (dbusy_ff) begin
            dcnt_ff <= dcnt_ff + 7'd1;
            if (dcnt_ff == 7'd95) dbusy_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pos_ff[0]  <= req_pos_x;
         pos_ff[1]  <= req_pos_y;
         pos_ff[2]  <= req_pos_z;
         disp_ff[0] <= req_disp_x;
         disp_ff[1] <= req_disp_y;
         disp_ff[2] <= req_disp_z;
         k_ff       <= req_force_const;
         t_ff       <= req_target_height;
         end_ff     <= req_list_end;
      end
      case (cmd.act)
         phe_pkg::ACT_P:    p_ff[cmd.idx] <= p_new;
         phe_pkg::ACT_HELD: begin
            for (int i = 0; i < 3; i++) begin
               if (cmd.idx == 2'd0) org_ff[i] <= p_ff[i];
               if (cmd.idx == 2'd1) rgt_ff[i] <= p_ff[i];
               if (cmd.idx == 2'd2) lft_ff[i] <= p_ff[i];
            end
         end
         phe_pkg::ACT_C0:     c_ff[0]   <= acc[63:0];
         phe_pkg::ACT_C1:     c_ff[1]   <= acc[63:0];
         phe_pkg::ACT_C2:     c_ff[2]   <= acc[63:0];
         phe_pkg::ACT_NORM:   norm2_ff  <= acc;
         phe_pkg::ACT_DOT:    dot_ff    <= acc;
         phe_pkg::ACT_ERR:    err_ff    <= acc[63:0];
         phe_pkg::ACT_E2:     e2_ff     <= acc[phe_pkg::ERR_SQ_SHIFT +: 96];
         phe_pkg::ACT_ENERGY: energy_ff <= energy_c;
         phe_pkg::ACT_HGT: begin
            if (degen) begin
               h_ff    <= '0;
               herr_ff <= '0;
            end else begin
               h_ff    <= h_q;
               herr_ff <= sat32(s64(h_q) - s64(t_ff));
            end
         end
         phe_pkg::ACT_FIN: begin
            rsp_term_energy    <= e_add;
            rsp_height         <= h_ff;
            rsp_height_error   <= herr_ff;
            rsp_term_counted   <= counted;
            rsp_running_energy <= sum_new;
            rsp_list_done      <= end_ff;
         end
         default: ;
      endcase

      // digit-by-digit square root, two radicand bits a step
      if (cmd.sqrt_start) begin
         src_ff  <= norm2_ff;
         srem_ff <= '0;
         root_ff <= '0;
      end else if (sbusy_ff) begin
         src_ff <= {src_ff[125:0], 2'b00};
         if (srem_t >= strial) begin
            srem_ff <= srem_t - strial;
            root_ff <= {root_ff[62:0], 1'b1};
         end else begin
            srem_ff <= srem_t;
            root_ff <= {root_ff[62:0], 1'b0};
         end
      end

      // restoring divide of |dot| by root, quotient shifts into dvd_ff
      if (cmd.div_start) begin
         dvd_ff  <= dmag;
         drem_ff <= '0;
         dneg_ff <= dot_ff[127];
      end else if (dbusy_ff) begin
         if (drem_t >= {1'b0, root_ff}) begin
            drem_ff <= drem_t[63:0] - root_ff;
            dvd_ff  <= {dvd_ff[94:0], 1'b1};
         end else begin
            drem_ff <= drem_t[63:0];
            dvd_ff  <= {dvd_ff[94:0], 1'b0};
         end
      end
   end

   always_comb begin
      stat.mul_busy  = mul_busy;
      stat.sqrt_busy = sbusy_ff;
      stat.div_busy  = dbusy_ff;
      stat.degen     = degen;
      stat.counted   = counted;
      stat.out_free  = ~rsp_valid_ff | ~rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

>>> hw/rtl/phe_ctrl.sv
`default_nettype none
module phe_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire phe_pkg::stat_type stat,
   output phe_pkg::cmd_type       cmd
);
   phe_pkg::state_type state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic [1:0] slot_ff, slot_in;
   logic [3:0] pc_ff, pc_in;
   phe_pkg::prog_type prog;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= phe_pkg::ST_IDLE;
         axis_ff  <= '0;
         slot_ff  <= '0;
         pc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         slot_ff  <= slot_in;
         pc_ff    <= pc_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      axis_in   = axis_ff;
      slot_in   = slot_ff;
      pc_in     = pc_ff;
      prog      = phe_pkg::prog_step(pc_ff);
      req_stall = 1'b1;
      cmd       = '{capture: 1'b0, mul_start: 1'b0, mop: phe_pkg::MOP_SHX, clr: 1'b0,
                    act: phe_pkg::ACT_NONE, idx: 2'd0, sqrt_start: 1'b0,
                    div_start: 1'b0};
      case (state_ff)
         phe_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               axis_in     = 2'd0;
               state_in    = phe_pkg::ST_SH_GO;
            end
         end
         phe_pkg::ST_SH_GO: begin
            cmd.mul_start = 1'b1;
            cmd.clr       = 1'b1;
            case (axis_ff)
               2'd0:    cmd.mop = phe_pkg::MOP_SHX;
               2'd1:    cmd.mop = phe_pkg::MOP_SHY;
               default: cmd.mop = phe_pkg::MOP_SHZ;
            endcase
            state_in = phe_pkg::ST_SH_WAIT;
         end
         phe_pkg::ST_SH_WAIT: begin
            cmd.idx = axis_ff;
            if (!stat.mul_busy) begin
               cmd.act = phe_pkg::ACT_P;
               if (axis_ff == 2'd2) begin
                  state_in = phe_pkg::ST_SLOT;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = phe_pkg::ST_SH_GO;
               end
            end
         end
         phe_pkg::ST_SLOT: begin
            if (slot_ff != 2'd3) begin
               cmd.act  = phe_pkg::ACT_HELD;
               cmd.idx  = slot_ff;
               slot_in  = slot_ff + 2'd1;
               state_in = phe_pkg::ST_IDLE;
            end else begin
               pc_in    = '0;
               state_in = phe_pkg::ST_MP_GO;
            end
         end
         phe_pkg::ST_MP_GO: begin
            cmd.mul_start = 1'b1;
            cmd.mop       = prog.mop;
            cmd.clr       = prog.clr;
            state_in      = phe_pkg::ST_MP_WAIT;
         end
         phe_pkg::ST_MP_WAIT: begin
            cmd.mop = prog.mop;
            if (!stat.mul_busy) begin
               cmd.act = prog.act;
               pc_in   = pc_ff + 4'd1;
               if (pc_ff == phe_pkg::PC_LAST_GEOM) state_in = phe_pkg::ST_SQ_GO;
               else if (pc_ff == phe_pkg::PC_LAST) state_in = phe_pkg::ST_FIN;
               else state_in = phe_pkg::ST_MP_GO;
            end
         end
         phe_pkg::ST_SQ_GO: begin
            cmd.sqrt_start = 1'b1;
            state_in       = phe_pkg::ST_SQ_WAIT;
         end
         phe_pkg::ST_SQ_WAIT: begin
            if (!stat.sqrt_busy) begin
               state_in = stat.degen ? phe_pkg::ST_HGT : phe_pkg::ST_DV_GO;
            end
         end
         phe_pkg::ST_DV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = phe_pkg::ST_DV_WAIT;
         end
         phe_pkg::ST_DV_WAIT: begin
            if (!stat.div_busy) state_in = phe_pkg::ST_HGT;
         end
         phe_pkg::ST_HGT: begin
            cmd.act  = phe_pkg::ACT_HGT;
            state_in = stat.counted ? phe_pkg::ST_MP_GO : phe_pkg::ST_FIN;
         end
         phe_pkg::ST_FIN: begin
            if (stat.out_free) begin
               cmd.act  = phe_pkg::ACT_FIN;
               slot_in  = '0;
               state_in = phe_pkg::ST_IDLE;
            end
         end
         default: state_in = phe_pkg::ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

>>> hw/rtl/pyramid_height_energy.sv
`default_nettype none
// Out-of-plane height energy. Atoms arrive one per transfer, four to a term
// (origin, right base, left base, apex); each is shifted by
// displacement_scale times its displacement, and the apex transfer yields one
// result: apex height over the base plane, height error, term energy
// k*(h*(1+w) - t*(1-w))^2 in Q32.32 and the running sum, which clears after
// the result flagged list_done. One item is worked at a time; req_stall is
// low only while the controller is idle. All products go through a single
// 32x32 multiplier, six partial products per multiply besides launch and
// drain. A base atom takes capture, three shift multiplies and the slot
// store; the apex takes capture and the shifts, then 12 multiplies for the
// cross, norm and dot products, the 64-step square root, the 96-step
// divide, the height, the energy multiplies and the finish step. A
// degenerate term skips the divide and the energy, an uncounted one only
// the energy.
// A finished result waits in its output register while the next term's
// atoms are taken. Configuration writes are accepted every cycle.
module pyramid_height_energy #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_pos_x,
   input  wire logic [31:0] req_pos_y,
   input  wire logic [31:0] req_pos_z,
   input  wire logic [31:0] req_disp_x,
   input  wire logic [31:0] req_disp_y,
   input  wire logic [31:0] req_disp_z,
   input  wire logic        req_atom_active,
   input  wire logic [31:0] req_force_const,
   input  wire logic [31:0] req_target_height,
   input  wire logic        req_list_end,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_term_energy,
   output logic [31:0]      rsp_height,
   output logic [31:0]      rsp_height_error,
   output logic             rsp_term_counted,
   output logic [63:0]      rsp_running_energy,
   output logic             rsp_list_done,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   phe_pkg::cmd_type  cmd;
   phe_pkg::stat_type stat;

   // register file never back-pressures
   assign csr_ready = 1'b1;

   phe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   phe_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_pos_z          (req_pos_z),
      .req_disp_x         (req_disp_x),
      .req_disp_y         (req_disp_y),
      .req_disp_z         (req_disp_z),
      .req_atom_active    (req_atom_active),
      .req_force_const    (req_force_const),
      .req_target_height  (req_target_height),
      .req_list_end       (req_list_end),
      .csr_valid          (csr_valid & csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_term_energy    (rsp_term_energy),
      .rsp_height         (rsp_height),
      .rsp_height_error   (rsp_height_error),
      .rsp_term_counted   (rsp_term_counted),
      .rsp_running_energy (rsp_running_energy),
      .rsp_list_done      (rsp_list_done)
   );

   // the shared units never run at the same time
   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({stat.mul_busy, stat.sqrt_busy, stat.div_busy}))
      else $error("more than one arithmetic unit busy");

   // a new atom is only taken with every unit quiet
   a_accept_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !(stat.mul_busy || stat.sqrt_busy || stat.div_busy))
      else $error("atom transfer while arithmetic busy");

   // a result only appears after the finish step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> $past(cmd.act == phe_pkg::ACT_FIN))
      else $error("result without finish step");
endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

   localparam int  FRAC = 16;
   localparam int  LIMIT_CYCLES = 1000000;
   localparam int  DRAIN_CYCLES = 400;      // roughly one apex worth of work
   localparam longint ONE = 64'sd65536;     // 1.0 in Q16.16

   typedef struct {
      logic [31:0] px, py, pz, dx, dy, dz;
      logic        act;
      logic [31:0] k, t;
      logic        last;
   } atom_type;

   typedef struct {
      logic [63:0] energy;
      logic [31:0] h, herr;
      logic        counted;
      logic [63:0] sum;
      logic        done;
   } term_result_type;

   logic        clock, reset;
   logic        req_valid, req_stall;
   logic [31:0] req_pos_x, req_pos_y, req_pos_z;
   logic [31:0] req_disp_x, req_disp_y, req_disp_z;
   logic        req_atom_active;
   logic [31:0] req_force_const, req_target_height;
   logic        req_list_end;
   logic        rsp_valid, rsp_stall;
   logic [63:0] rsp_term_energy, rsp_running_energy;
   logic [31:0] rsp_height, rsp_height_error;
   logic        rsp_term_counted, rsp_list_done;
   logic        csr_valid, csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   pyramid_height_energy uut (.*);

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   // ---------------------------------------------------------------------------
   // Predictor state: a private copy of the block's registers and term state
   // ---------------------------------------------------------------------------
   logic signed [17:0] step_scale;
   logic               homo_on;
   logic [16:0]        homo_w;
   int                 atoms_held;
   longint             base_pos [9];
   logic               term_active;
   logic [63:0]        energy_total;

   term_result_type expected_terms [$];

   int error_count;
   int snd_idle_pct, rcv_idle_pct;
   int hold_tag, hold_len;
   longint cycle_count;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [127:0] n);
      logic [63:0]  r, c;
      logic [127:0] cc;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         cc = {64'd0, c} * {64'd0, c};
         if (n >= cc) r = c;
      end
      return r;
   endfunction

   // Work one accepted atom; on the apex queue the expected term result.
   task automatic predict_atom(input atom_type a);
      longint p [3], d [3][3], c [3], raw, v, h, herr, w, t, err;
      logic signed [127:0] norm2, dot, cw;
      logic [127:0] thr, mag, q, e2, prod;
      logic [63:0]  root, m, energy;
      logic [64:0]  s;
      logic         degen, counted, skip_w;
      term_result_type r;
      h = 0; herr = 0; w = 0; energy = '0; skip_w = 1'b0;
      for (int i = 0; i < 3; i++) begin
         raw = longint'(signed'(i == 0 ? a.dx : i == 1 ? a.dy : a.dz));
         v = longint'(signed'(i == 0 ? a.px : i == 1 ? a.py : a.pz));
         p[i] = clamp32(v + ((longint'(step_scale) * raw) >>> 16));
      end
      term_active = term_active | a.act;
      if (atoms_held < 3) begin
         for (int i = 0; i < 3; i++) base_pos[3 * atoms_held + i] = p[i];
         atoms_held++;
         return;
      end
      for (int j = 0; j < 3; j++)
         for (int i = 0; i < 3; i++)
            d[j][i] = clamp32((j < 2 ? base_pos[3 * (j + 1) + i] : p[i]) - base_pos[i]);
      // cross product in 64 bits, wrapping as the hardware word does
      c[0] = d[0][1] * d[1][2] - d[1][1] * d[0][2];
      c[1] = d[1][0] * d[0][2] - d[0][0] * d[1][2];
      c[2] = d[0][0] * d[1][1] - d[1][0] * d[0][1];
      norm2 = '0; dot = '0;
      for (int i = 0; i < 3; i++) begin
         cw = c[i];
         norm2 = norm2 + cw * cw;
         dot = dot + cw * 128'(signed'(d[2][i]));
      end
      // 1e-16 in real units, scaled by 2^(4*FRAC)
      thr = ((128'd1 << (4 * FRAC - 16)) / 128'd152587890625) + 128'd1;
      degen = $unsigned(norm2) < thr;
      if (!degen) begin
         root = int_sqrt(norm2);
         if (root == 0) degen = 1'b1;
         else begin
            mag = dot[127] ? -dot : dot;
            q = mag / {64'd0, root};
            if (dot[127]) h = (q > 128'h80000000) ? -64'sd2147483648 : -longint'(q[63:0]);
            else h = (q > 128'h7fffffff) ? 64'sd2147483647 : longint'(q[63:0]);
            herr = clamp32(h - longint'(signed'(a.t)));
         end
      end
      if (homo_on) begin
         if (homo_w >= 17'd65536) skip_w = 1'b1;
         else w = longint'(homo_w);
      end
      counted = term_active && !degen && !skip_w;
      if (counted) begin
         t = longint'(signed'(a.t));
         err = h * (ONE + w) - t * (ONE - w);
         m = err < 0 ? -err : err;
         e2 = ({64'd0, m} * {64'd0, m}) >> 32;
         prod = (e2 * {96'd0, a.k}) >> FRAC;
         energy = (prod[127:64] != 0) ? '1 : prod[63:0];
         s = {1'b0, energy_total} + {1'b0, energy};
         energy_total = s[64] ? '1 : s[63:0];
      end
      r.energy = energy;
      r.h = h[31:0];
      r.herr = herr[31:0];
      r.counted = counted;
      r.sum = energy_total;
      r.done = a.last;
      expected_terms.push_back(r);
      if (a.last) energy_total = '0;
      atoms_held = 0;
      term_active = 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Result side: random stall with a long hold-off on request, and the checker
   // ---------------------------------------------------------------------------
   int hold_seen, hold_cnt;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_seen <= hold_tag;
         hold_cnt  <= 0;
      end else begin
         if (hold_seen != hold_tag) begin
            hold_seen <= hold_tag;
            hold_cnt  <= hold_len;
            rsp_stall <= 1'b1;
         end else if (hold_cnt > 0) begin
            hold_cnt  <= hold_cnt - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         term_result_type e;
         if (expected_terms.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("ERROR: unexpected result transfer, energy %h", rsp_term_energy);
         end else begin
            e = expected_terms.pop_front();
            if (rsp_term_energy !== e.energy || rsp_height !== e.h
                || rsp_height_error !== e.herr || rsp_term_counted !== e.counted
                || rsp_running_energy !== e.sum || rsp_list_done !== e.done) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("ERROR: result mismatch");
                  $display("  exp energy %h h %h herr %h cnt %b sum %h done %b",
                           e.energy, e.h, e.herr, e.counted, e.sum, e.done);
                  $display("  got energy %h h %h herr %h cnt %b sum %h done %b",
                           rsp_term_energy, rsp_height, rsp_height_error,
                           rsp_term_counted, rsp_running_energy, rsp_list_done);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------------
   // Called at a rising edge; valid stays high after the transfer so that
   // back-to-back atoms carry no gap unless the idle draw asks for one.
   task automatic send_atom(input atom_type a);
      int gap;
      gap = 0;
      while ($urandom_range(99) < snd_idle_pct && gap < 8) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_pos_x         <= a.px;
      req_pos_y         <= a.py;
      req_pos_z         <= a.pz;
      req_disp_x        <= a.dx;
      req_disp_y        <= a.dy;
      req_disp_z        <= a.dz;
      req_atom_active   <= a.act;
      req_force_const   <= a.k;
      req_target_height <= a.t;
      req_list_end      <= a.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_atom(a);
   endtask

   // Leaves csr_valid high; the caller drops it after its last write.
   task automatic write_csr(input logic [1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         phe_pkg::CSR_SCALE:   step_scale = val[17:0];
         phe_pkg::CSR_HOMO_EN: homo_on = val[0];
         phe_pkg::CSR_HOMO_W:  homo_w = val[16:0];
         default: ;
      endcase
   endtask

   // Block must be idle before register writes: all results in, then drain.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_terms.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input int sc, input bit en, input int wt);
      settle();
      write_csr(phe_pkg::CSR_SCALE, sc);
      write_csr(phe_pkg::CSR_HOMO_EN, en);
      write_csr(phe_pkg::CSR_HOMO_W, wt);
      csr_valid <= 1'b0;
   endtask

   function automatic atom_type mk_atom(int x, int y, int z, bit act);
      atom_type a;
      a.px = x; a.py = y; a.pz = z;
      a.dx = '0; a.dy = '0; a.dz = '0;
      a.act = act; a.k = ONE; a.t = ONE; a.last = 1'b0;
      return a;
   endfunction

   function automatic logic [31:0] rnd_coord(int span);
      return $urandom_range(2 * span) - span;
   endfunction

   // Random atom near a given point; a few are full-range noise.
   function automatic atom_type rnd_atom(int cx, int cy, int cz);
      atom_type a;
      if ($urandom_range(15) == 0) begin
         a.px = $urandom; a.py = $urandom; a.pz = $urandom;
         a.dx = $urandom; a.dy = $urandom; a.dz = $urandom;
      end else begin
         a.px = cx + rnd_coord(4 << 16);
         a.py = cy + rnd_coord(4 << 16);
         a.pz = cz + rnd_coord(4 << 16);
         a.dx = rnd_coord(1 << 16); a.dy = rnd_coord(1 << 16); a.dz = rnd_coord(1 << 16);
      end
      a.act  = ($urandom_range(3) != 0);
      a.k    = ($urandom_range(7) == 0) ? $urandom : $urandom_range(32 << 16);
      a.t    = ($urandom_range(7) == 0) ? $urandom : rnd_coord(8 << 16);
      a.last = $urandom_range(1);
      return a;
   endfunction

   task automatic send_random_term();
      atom_type o, r, l, ap;
      int cx, cy, cz;
      cx = rnd_coord(1 << 24); cy = rnd_coord(1 << 24); cz = rnd_coord(1 << 24);
      o = rnd_atom(cx, cy, cz);
      r = rnd_atom(cx, cy, cz);
      l = rnd_atom(cx, cy, cz);
      ap = rnd_atom(cx, cy, cz);
      if ($urandom_range(15) == 0) l = r;               // collinear base
      if ($urandom_range(7) == 0) begin                 // nothing active
         o.act = 0; r.act = 0; l.act = 0; ap.act = 0;
      end
      ap.last = ($urandom_range(3) == 0);
      send_atom(o); send_atom(r); send_atom(l); send_atom(ap);
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------
   task automatic test_directed();
      atom_type a;
      snd_idle_pct = 0; rcv_idle_pct = 0;
      // unit pyramid, apex 2.0 above base, target 1.0
      send_atom(mk_atom(0, 0, 0, 1));
      send_atom(mk_atom(65536, 0, 0, 0));
      send_atom(mk_atom(0, 65536, 0, 0));
      send_atom(mk_atom(0, 0, 131072, 0));
      // degenerate base: all three base atoms in one place, ends the list
      send_atom(mk_atom(65536, 65536, 65536, 1));
      send_atom(mk_atom(65536, 65536, 65536, 1));
      send_atom(mk_atom(65536, 65536, 65536, 1));
      a = mk_atom(0, 0, 65536, 1); a.last = 1; send_atom(a);
      // no active atom, apex below the plane; stray fields on the origin atom
      a = mk_atom(0, 0, 0, 0); a.last = 1; a.k = '1; a.t = 32'h80000000; send_atom(a);
      send_atom(mk_atom(0, 131072, 0, 0));
      send_atom(mk_atom(131072, 0, 0, 0));
      send_atom(mk_atom(0, 0, -196608, 0));
      // coordinate extremes, saturating differences, height and energy
      set_config(131071, 0, 0);
      a = mk_atom(32'h80000000, 32'h80000000, 32'h80000000, 1);
      a.dx = 32'h80000000; a.dy = 32'h80000000; a.dz = 32'h80000000; send_atom(a);
      a = mk_atom(32'h7fffffff, 32'h80000000, 0, 0);
      a.dx = 32'h7fffffff; send_atom(a);
      a = mk_atom(32'h80000000, 32'h7fffffff, 0, 0);
      a.dy = 32'h7fffffff; send_atom(a);
      a = mk_atom(0, 0, 32'h7fffffff, 1);
      a.dz = 32'h7fffffff; a.k = '1; a.t = 32'h80000000; a.last = 1; send_atom(a);
      // large finite height with maximal force constant
      set_config(-131072, 0, 0);
      send_atom(mk_atom(0, 0, 0, 1));
      send_atom(mk_atom(1, 0, 0, 1));
      send_atom(mk_atom(0, 1, 0, 1));
      a = mk_atom(5, -7, 32'h40000000, 1); a.dz = 32'h7fffffff; a.k = '1;
      a.t = 32'h7fffffff; send_atom(a);
      // tiny but non-degenerate base just above the threshold
      a = mk_atom(0, 0, 0, 1); a.k = 0; send_atom(a);
      send_atom(mk_atom(43, 0, 0, 0));
      send_atom(mk_atom(0, 1, 0, 0));
      a = mk_atom(0, 0, 1, 0); a.k = 0; a.t = 0; send_atom(a);
   endtask

   task automatic test_random_phase(input int terms, input int sc, input bit en,
                                    input int wt, input int snd, input int rcv);
      set_config(sc, en, wt);
      snd_idle_pct = snd; rcv_idle_pct = rcv;
      repeat (terms) send_random_term();
   endtask

   // Receiver holds off while atoms keep coming, so the block's output
   // register fills and the request side must stall.
   task automatic test_backpressure();
      set_config($urandom_range(131071), 1, $urandom_range(65535));
      snd_idle_pct = 0; rcv_idle_pct = 0;
      hold_len = 3000;
      hold_tag++;
      repeat (37) send_random_term();
   endtask

   initial begin
      error_count = 0; cycle_count = 0;
      hold_tag = 0; hold_len = 0;
      snd_idle_pct = 0; rcv_idle_pct = 0;
      step_scale = '0; homo_on = 1'b0; homo_w = '0;
      atoms_held = 0; term_active = 1'b0; energy_total = '0;
      foreach (base_pos[i]) base_pos[i] = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_pos_x <= '0; req_pos_y <= '0; req_pos_z <= '0;
      req_disp_x <= '0; req_disp_y <= '0; req_disp_z <= '0;
      req_atom_active <= 1'b0; req_force_const <= '0;
      req_target_height <= '0; req_list_end <= 1'b0;
      csr_valid <= 1'b0; csr_index <= '0; csr_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      // sender idles 17%, receiver 69%
      test_random_phase(60, 0, 0, 0, 17, 69);
      test_random_phase(60, 131071, 1, 0, 17, 69);
      // roles swapped
      test_random_phase(60, -131072, 1, 65536, 69, 17);
      test_random_phase(60, $urandom_range(262143), 1, 131071, 69, 17);
      // no idling
      test_random_phase(40, $urandom_range(65535), 1, $urandom_range(65535), 0, 0);
      test_random_phase(40, 65536, 0, 1000, 0, 0);
      test_backpressure();

      settle();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
